@@ hdl/tps_pkg.sv @@
// Shared types, register indexes and constants of the thermal power supervisor.
`timescale 1ns / 1ps

package tps_pkg;

  localparam int CHECK_PERIOD = 100;
  localparam int CHECK_W      = 7;

  localparam int DIVIDEND_W = 21;
  localparam logic [DIVIDEND_W-1:0] FAN_DIVIDEND = 21'd2022436;
  localparam int DIVISOR_W  = 16;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = 5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_UVLO_ENABLE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UVLO_ADC_MIN      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FAN_ON_ADC_MAX    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOT_SET_ADC_MAX   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HOT_CLEAR_ADC_MIN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS        = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_LED_OFF_TICKS     = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_LED_ON_TICKS      = 3'd7;

  localparam logic [1:0] CAUSE_NONE   = 2'd0;
  localparam logic [1:0] CAUSE_BUTTON = 2'd1;
  localparam logic [1:0] CAUSE_UVLO   = 2'd2;

  localparam logic [7:0] FAN_MAX     = 8'd250;
  localparam logic [7:0] FAN_MIN     = 8'd30;
  localparam logic [DIVIDEND_W-1:0] FAN_Q_OFFSET = 21'd132;
  localparam logic [DIVIDEND_W-1:0] FAN_N_CLAMP  = 21'd100;

  typedef struct packed {
    logic        button_pressed;
    logic [11:0] vin_sample;
    logic [11:0] temp_sample;
  } in_t;

  typedef struct packed {
    logic [7:0] fan_compare;
    logic       over_temp;
    logic       over_temp_event;
    logic       status_led;
    logic       shutdown_request;
    logic [1:0] shutdown_cause;
  } out_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ hdl/thermal_power_supervisor_top.sv @@
// Top level of the thermal power supervisor.
`timescale 1ns / 1ps

// Takes one 1 ms tick per transfer and returns one status result per tick.
// Each tick runs through a radix-2 restoring divider for the fan curve, one
// quotient bit per cycle; a tick passes through an accept state, 21 divider
// steps and a commit state, which waits for a free output, before the next transfer.
// A result waits in the output register while the next tick is taken in; the
// commit of that next tick waits only if the previous result is still held.
// Configuration writes take effect at once and belong between ticks.
module thermal_power_supervisor_top import tps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cmd_t    cmd;
  status_t status;

  tps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tps_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/tps_ctrl.sv @@
// Controller state machine: transfer, divider sequencing and commit.
`timescale 1ns / 1ps

module tps_ctrl import tps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DIV    = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_CNT_W-1:0] count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          count_next = DIV_CNT_W'(DIV_STEPS - 1);
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step   = 1'b1;
        count_next = count - 1'b1;
        if (count == '0) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  a_load_to_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_DIV && count == DIV_CNT_W'(DIV_STEPS - 1))
    else $error("divider not started after transfer");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && count == '0 |=> state == S_COMMIT)
    else $error("divider sequence did not end in commit");

  a_commit_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> $past(state) == S_DIV || $past(state) == S_COMMIT)
    else $error("commit without a finished division");

endmodule

@@ hdl/tps_datapath.sv @@
// Datapath: configuration, supervisor state, serial divider and output register.
`timescale 1ns / 1ps

module tps_datapath import tps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  in_t                    in_data,
  input  cmd_t                   cmd,
  output status_t                status,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_t                   out_data
);

  logic        uvlo_enable;
  logic [11:0] uvlo_adc_min;
  logic [11:0] fan_on_adc_max;
  logic [11:0] hot_set_adc_max;
  logic [11:0] hot_clear_adc_min;
  logic [15:0] hold_ticks;
  logic [15:0] led_off_ticks;
  logic [15:0] led_on_ticks;

  logic [CHECK_W-1:0] check_elapsed;
  logic [15:0]        led_elapsed;
  logic               led_lit;
  logic [15:0]        hold_elapsed;
  logic               over_temp_state;
  logic [7:0]         fan_level;
  logic               halted;

  logic [CHECK_W-1:0] check_elapsed_next;
  logic [15:0]        led_elapsed_next;
  logic               led_lit_next;
  logic [15:0]        hold_elapsed_next;
  logic               over_temp_state_next;
  logic [7:0]         fan_level_next;
  logic               halted_next;
  out_t               result_next;

  in_t                   item;
  logic [DIVIDEND_W-1:0] dq;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  divisor;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W+1:0]  diff;

  logic [DIVIDEND_W-1:0] fan_n;
  logic [8:0]            fan_v;
  logic [7:0]            fan_calc;
  logic [CHECK_W-1:0]    check_inc;
  logic                  check_hit;
  logic [15:0]           led_inc;
  logic [15:0]           hold_inc;
  logic                  request;

  always_ff @(posedge clk) begin
    if (rst) begin
      uvlo_enable       <= 1'b0;
      uvlo_adc_min      <= 12'd2571;
      fan_on_adc_max    <= 12'd1532;
      hot_set_adc_max   <= 12'd722;
      hot_clear_adc_min <= 12'd778;
      hold_ticks        <= 16'd200;
      led_off_ticks     <= 16'd100;
      led_on_ticks      <= 16'd500;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UVLO_ENABLE:       uvlo_enable       <= cfg_data[0];
        REG_UVLO_ADC_MIN:      uvlo_adc_min      <= cfg_data[11:0];
        REG_FAN_ON_ADC_MAX:    fan_on_adc_max    <= cfg_data[11:0];
        REG_HOT_SET_ADC_MAX:   hot_set_adc_max   <= cfg_data[11:0];
        REG_HOT_CLEAR_ADC_MIN: hot_clear_adc_min <= cfg_data[11:0];
        REG_HOLD_TICKS:        hold_ticks        <= cfg_data;
        REG_LED_OFF_TICKS:     led_off_ticks     <= cfg_data;
        REG_LED_ON_TICKS:      led_on_ticks      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // restoring divider, one quotient bit per step
  assign divisor = {1'b0, item.temp_sample, 3'b000} + {3'b000, item.temp_sample, 1'b0};
  assign rem_sh  = {rem, dq[DIVIDEND_W-1]};
  assign diff    = {1'b0, rem_sh} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
      dq   <= FAN_DIVIDEND;
      rem  <= '0;
    end else if (cmd.step) begin
      dq  <= {dq[DIVIDEND_W-2:0], ~diff[DIVISOR_W+1]};
      rem <= diff[DIVISOR_W+1] ? rem_sh[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
    end
  end

  // fan compare from the quotient
  always_comb begin
    fan_n    = dq - FAN_Q_OFFSET;
    fan_v    = ({2'b00, fan_n[6:0]} << 2) + {2'b00, fan_n[6:0]};
    fan_v    = fan_v >> 1;
    if (item.temp_sample == '0) begin
      fan_calc = FAN_MAX;
    end else if (dq < FAN_Q_OFFSET) begin
      fan_calc = '0;
    end else if (fan_n > FAN_N_CLAMP) begin
      fan_calc = FAN_MAX;
    end else if (fan_v < {1'b0, FAN_MIN}) begin
      fan_calc = '0;
    end else begin
      fan_calc = fan_v[7:0];
    end
  end

  always_comb begin
    check_elapsed_next   = check_elapsed;
    led_elapsed_next     = led_elapsed;
    led_lit_next         = led_lit;
    hold_elapsed_next    = hold_elapsed;
    over_temp_state_next = over_temp_state;
    fan_level_next       = fan_level;
    halted_next          = halted;
    request              = 1'b0;
    result_next          = '0;
    result_next.shutdown_cause = CAUSE_NONE;
    check_inc = check_elapsed + 1'b1;
    check_hit = check_inc >= CHECK_W'(CHECK_PERIOD);
    led_inc   = (led_elapsed == 16'hFFFF) ? led_elapsed : led_elapsed + 1'b1;
    hold_inc  = (hold_elapsed == 16'hFFFF) ? hold_elapsed : hold_elapsed + 1'b1;
    if (!halted) begin
      check_elapsed_next = check_hit ? '0 : check_inc;
      if (check_hit) begin
        if (item.temp_sample <= fan_on_adc_max) begin
          fan_level_next = fan_calc;
        end
        if (item.temp_sample <= hot_set_adc_max && !over_temp_state) begin
          over_temp_state_next        = 1'b1;
          result_next.over_temp_event = 1'b1;
        end else if (item.temp_sample >= hot_clear_adc_min) begin
          over_temp_state_next = 1'b0;
        end
        if (uvlo_enable && item.vin_sample < uvlo_adc_min) begin
          request                    = 1'b1;
          result_next.shutdown_cause = CAUSE_UVLO;
          halted_next                = 1'b1;
        end
      end
      if (!request) begin
        led_elapsed_next = led_inc;
        if (!led_lit && led_inc >= led_off_ticks) begin
          led_lit_next     = 1'b1;
          led_elapsed_next = '0;
        end else if (led_lit && led_inc >= led_on_ticks) begin
          led_lit_next     = 1'b0;
          led_elapsed_next = '0;
        end
        if (item.button_pressed) begin
          hold_elapsed_next = hold_inc;
          if (hold_inc >= hold_ticks) begin
            request                    = 1'b1;
            result_next.shutdown_cause = CAUSE_BUTTON;
            halted_next                = 1'b1;
          end
        end else begin
          hold_elapsed_next = '0;
        end
      end
    end
    result_next.fan_compare      = fan_level_next;
    result_next.over_temp        = over_temp_state_next;
    result_next.status_led       = led_lit_next;
    result_next.shutdown_request = request;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_elapsed   <= '0;
      led_elapsed     <= '0;
      led_lit         <= 1'b0;
      hold_elapsed    <= '0;
      over_temp_state <= 1'b0;
      fan_level       <= '0;
      halted          <= 1'b0;
    end else if (cmd.commit) begin
      check_elapsed   <= check_elapsed_next;
      led_elapsed     <= led_elapsed_next;
      led_lit         <= led_lit_next;
      hold_elapsed    <= hold_elapsed_next;
      over_temp_state <= over_temp_state_next;
      fan_level       <= fan_level_next;
      halted          <= halted_next;
    end
  end

  // hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= result_next;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

endmodule
